// File: hw/rtl/omni_wheel_kinematics_core_macros.svh
// assertion macros for the omni wheel kinematics core
`ifndef OMNI_WHEEL_KINEMATICS_CORE_MACROS_SVH
`define OMNI_WHEEL_KINEMATICS_CORE_MACROS_SVH
// assert a property under the active-low synchronous reset
`define OWK_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// assert a property at every edge, reset included
`define OWK_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`endif

// File: hw/rtl/owk_pkg.sv
// shared types, constants and sine table function for the omni wheel kinematics core
`default_nettype none
package owk_pkg;
    localparam int SINE_ENTRIES_DEF = 256;
    localparam int FULL_TURN = 23040;
    localparam int QUARTER_TURN = 5760;
    localparam int HALF_QUARTER = 2880;
    localparam int ANG_W = 15;
    localparam int SINE_W = 16;
    localparam int VAL_W = 16;
    localparam int WOUT_W = 14;
    localparam int BODY_W = 32;
    localparam int SCALE_W = 24;
    localparam int NUM_WHEELS = 4;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 24;
    localparam int ACT_W = 2;
    localparam int IN_TDATA_W = 136;
    localparam int OUT_TDATA_W = 152;

    typedef enum logic [ACT_W-1:0] {
        ACT_INVERSE  = 2'd0,
        ACT_FWD_VEL  = 2'd1,
        ACT_FWD_ODOM = 2'd2,
        ACT_FWD_ALT  = 2'd3
    } t_action;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MOUNT_0 = 3'd0,
        CFG_MOUNT_1 = 3'd1,
        CFG_MOUNT_2 = 3'd2,
        CFG_MOUNT_3 = 3'd3,
        CFG_ODOM    = 3'd4
    } t_cfg_idx;

    // per-item control carried down the lanes and into the merge
    typedef struct packed {
        logic    valid;
        t_action action;
    } t_ctl;

    // quarter-wave sine entry in Q2.14, taylor series in Q2.30 as the spec builds it
    function automatic logic [SINE_W-1:0] sine_entry(input int k, input int n_entries);
        logic [63:0] th;
        logic [63:0] x2;
        logic [63:0] term;
        longint      acc;
        longint      e;
        th = (64'd1686629713 * 64'(k)) / 64'(n_entries);
        x2 = (th * th) >> 30;
        term = th;
        acc = longint'(th);
        for (int n = 1; n <= 10; n++) begin
            term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
            if ((n & 1) == 1) acc = acc - longint'(term);
            else acc = acc + longint'(term);
        end
        if (acc < 0) acc = 0;
        e = (acc + 32768) >>> 16;
        if (e > 16384) e = 16384;
        return SINE_W'(e);
    endfunction
endpackage
`default_nettype wire

// File: hw/rtl/owk_lane.sv
// one wheel lane: angle reduction, sine and cosine lookup, products for both directions
`default_nettype none
module owk_lane
    import owk_pkg::*;
#(
    parameter int SINE_ENTRIES = SINE_ENTRIES_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_en,
    input  wire logic [ANG_W-1:0]          i_heading,
    input  wire logic [ANG_W-1:0]          i_mount,
    input  wire logic signed [VAL_W-1:0]   i_vel_x,
    input  wire logic signed [VAL_W-1:0]   i_vel_y,
    input  wire logic signed [VAL_W-1:0]   i_rot,
    input  wire logic signed [VAL_W-1:0]   i_wheel,
    output logic signed [WOUT_W-1:0]       o_wheel_out,
    output logic signed [33:0]             o_px,
    output logic signed [33:0]             o_py
);
    localparam int IDX_W = $clog2(SINE_ENTRIES + 1);
    localparam int MULW = 13 + $clog2(SINE_ENTRIES) + 2;
    localparam int QW = MULW + 20;
    localparam logic [26:0] DIV45_M = 27'd95443718;

    logic [SINE_W-1:0] c_tab [SINE_ENTRIES+1];
    always_comb begin
        for (int k = 0; k <= SINE_ENTRIES; k++) c_tab[k] = sine_entry(k, SINE_ENTRIES);
    end

    // stage 1: angle mod full turn (sum < 3 turns)
    logic [ANG_W:0] n_sum;
    logic [ANG_W:0] n_ang;
    logic [ANG_W-1:0] r_ang;
    logic signed [VAL_W-1:0] r_vx, r_vy, r_w, r_wh;
    always_comb begin
        n_sum = {1'b0, i_heading} + {1'b0, i_mount};
        n_ang = n_sum;
        if (n_ang >= (ANG_W+1)'(FULL_TURN)) n_ang = n_ang - (ANG_W+1)'(FULL_TURN);
        if (n_ang >= (ANG_W+1)'(FULL_TURN)) n_ang = n_ang - (ANG_W+1)'(FULL_TURN);
    end
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ang <= n_ang[ANG_W-1:0];
            r_vx <= i_vel_x; r_vy <= i_vel_y; r_w <= i_rot; r_wh <= i_wheel;
        end
    end

    // floor(p / 5760): shift out 2^7, then multiply by the reciprocal of 45
    function automatic logic [MULW-1:0] div_quarter(input logic [MULW-1:0] p);
        logic [QW-1:0] prod;
        prod = QW'(p[MULW-1:7]) * QW'(DIV45_M);
        return MULW'(prod >> 32);
    endfunction

    // sine of an angle in [0, FULL_TURN)
    function automatic logic signed [SINE_W:0] sine_of(input logic [ANG_W-1:0] a,
                                                      input logic [SINE_W-1:0] t [SINE_ENTRIES+1]);
        logic [1:0]       q;
        logic [12:0]      r;
        logic [MULW-1:0]  pi, pj;
        logic [MULW-1:0]  ii, jj;
        logic [SINE_W:0]  v;
        priority if (a >= ANG_W'(3 * QUARTER_TURN)) begin
            q = 2'd3;
            r = 13'(a - ANG_W'(3 * QUARTER_TURN));
        end else if (a >= ANG_W'(2 * QUARTER_TURN)) begin
            q = 2'd2;
            r = 13'(a - ANG_W'(2 * QUARTER_TURN));
        end else if (a >= ANG_W'(QUARTER_TURN)) begin
            q = 2'd1;
            r = 13'(a - ANG_W'(QUARTER_TURN));
        end else begin
            q = 2'd0;
            r = 13'(a);
        end
        pi = MULW'(r) * MULW'(SINE_ENTRIES) + MULW'(HALF_QUARTER);
        pj = (MULW'(QUARTER_TURN) - MULW'(r)) * MULW'(SINE_ENTRIES) + MULW'(HALF_QUARTER);
        ii = div_quarter(pi);
        jj = div_quarter(pj);
        if (ii > MULW'(SINE_ENTRIES)) ii = MULW'(SINE_ENTRIES);
        if (jj > MULW'(SINE_ENTRIES)) jj = MULW'(SINE_ENTRIES);
        v = {1'b0, (q[0] ? t[jj[IDX_W-1:0]] : t[ii[IDX_W-1:0]])};
        return q[1] ? -$signed(v) : $signed(v);
    endfunction

    // stage 2: table lookups
    logic [ANG_W:0] n_cang;
    logic signed [SINE_W:0] r_sn, r_cs;
    logic signed [VAL_W-1:0] r2_vx, r2_vy, r2_w, r2_wh;
    always_comb begin
        n_cang = {1'b0, r_ang} + (ANG_W+1)'(QUARTER_TURN);
        if (n_cang >= (ANG_W+1)'(FULL_TURN)) n_cang = n_cang - (ANG_W+1)'(FULL_TURN);
    end
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sn <= sine_of(r_ang, c_tab);
            r_cs <= sine_of(n_cang[ANG_W-1:0], c_tab);
            r2_vx <= r_vx; r2_vy <= r_vy; r2_w <= r_w; r2_wh <= r_wh;
        end
    end

    // stage 3: products
    logic signed [33:0] r_ix, r_iy, r_iw;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ix <= 34'(-r_sn * r2_vx);
            r_iy <= 34'(r_cs * r2_vy);
            r_iw <= 34'(r2_w) <<< 14;
            o_px <= 34'(-r_sn * r2_wh);
            o_py <= 34'(r_cs * r2_wh);
        end
    end

    // stage 4: inverse sum, round half away from zero, saturate
    logic signed [35:0] n_s;
    logic [35:0]        n_mag;
    logic [35:0]        n_rm;
    logic signed [35:0] n_r;
    always_comb begin
        n_s = 36'(r_ix) + 36'(r_iy) + 36'(r_iw);
        n_mag = n_s[35] ? 36'(-n_s) : 36'(n_s);
        n_rm = (n_mag + 36'(1 << 17)) >> 18;
        n_r = n_s[35] ? -$signed(n_rm) : $signed(n_rm);
    end
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (n_r > 36'sd8191) o_wheel_out <= 14'sd8191;
            else if (n_r < -36'sd8192) o_wheel_out <= -14'sd8192;
            else o_wheel_out <= n_r[WOUT_W-1:0];
        end
    end
endmodule
`default_nettype wire

// File: hw/rtl/owk_merge.sv
// merge: sums lane projections into body x, y and rotation; scales for odometry
`default_nettype none
module owk_merge
    import owk_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_en,
    input  wire t_action                 i_action,
    input  wire logic [SCALE_W-1:0]      i_scale,
    input  wire logic signed [33:0]      i_px [NUM_WHEELS],
    input  wire logic signed [33:0]      i_py [NUM_WHEELS],
    input  wire logic signed [VAL_W-1:0] i_wh [NUM_WHEELS],
    output logic signed [BODY_W-1:0]     o_bx,
    output logic signed [BODY_W-1:0]     o_by,
    output logic signed [BODY_W-1:0]     o_br
);
    function automatic logic signed [BODY_W-1:0] rnd_sat(input logic signed [63:0] v,
                                                         input int k);
        logic [63:0]        mag;
        logic signed [63:0] r;
        mag = v[63] ? 64'(-v) : 64'(v);
        if (k > 0) mag = (mag + (64'd1 << (k - 1))) >> k;
        r = v[63] ? -$signed(mag) : $signed(mag);
        if (r > 64'sd2147483647) return 32'sh7fffffff;
        if (r < -64'sd2147483648) return 32'sh80000000;
        return r[BODY_W-1:0];
    endfunction

    // stage a: sums; scale captured alongside
    logic signed [35:0] r_sx, r_sy;
    logic signed [17:0] r_sw;
    t_action            r_act;
    logic [SCALE_W-1:0] r_scale;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sx <= 36'(i_px[0]) + 36'(i_px[1]) + 36'(i_px[2]) + 36'(i_px[3]);
            r_sy <= 36'(i_py[0]) + 36'(i_py[1]) + 36'(i_py[2]) + 36'(i_py[3]);
            r_sw <= 18'(i_wh[0]) + 18'(i_wh[1]) + 18'(i_wh[2]) + 18'(i_wh[3]);
            r_act <= i_action;
            r_scale <= i_scale;
        end
    end

    // stage b: odometry products, 36x25 cut as two halves of the sum
    logic signed [63:0] r_mx_lo, r_mx_hi, r_my_lo, r_my_hi, r_mw;
    logic signed [35:0] r2_sx, r2_sy;
    logic signed [17:0] r2_sw;
    t_action            r2_act;
    logic signed [24:0] n_sc;
    assign n_sc = $signed({1'b0, r_scale});
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mx_lo <= 64'($signed({1'b0, r_sx[17:0]}) * n_sc);
            r_mx_hi <= 64'($signed(r_sx[35:18]) * n_sc);
            r_my_lo <= 64'($signed({1'b0, r_sy[17:0]}) * n_sc);
            r_my_hi <= 64'($signed(r_sy[35:18]) * n_sc);
            r_mw <= 64'(r_sw * n_sc);
            r2_sx <= r_sx; r2_sy <= r_sy; r2_sw <= r_sw; r2_act <= r_act;
        end
    end

    logic signed [63:0] n_px, n_py;
    assign n_px = (r_mx_hi <<< 18) + r_mx_lo;
    assign n_py = (r_my_hi <<< 18) + r_my_lo;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            unique case (r2_act)
                ACT_INVERSE: begin
                    o_bx <= '0; o_by <= '0; o_br <= '0;
                end
                ACT_FWD_VEL: begin
                    o_bx <= rnd_sat(64'(r2_sx), 7);
                    o_by <= rnd_sat(64'(r2_sy), 7);
                    o_br <= rnd_sat(64'(r2_sw) <<< 6, 0);
                end
                ACT_FWD_ODOM, ACT_FWD_ALT: begin
                    o_bx <= rnd_sat(n_px, 23);
                    o_by <= rnd_sat(n_py, 23);
                    o_br <= rnd_sat(r_mw, 10);
                end
                default: begin
                    o_bx <= '0; o_by <= '0; o_br <= '0;
                end
            endcase
        end
    end
endmodule
`default_nettype wire

// File: hw/rtl/omni_wheel_kinematics_core.sv
// throughput: one item per cycle unless the output beat is stalled
// four wheel lanes and the merge stage run in parallel
// the whole pipeline advances together and holds while the output beat is stalled
// synchronous active-low reset clears stage valids and loads default mount angles
// and odometry scale; no clearing pass, the block is ready right after reset
`default_nettype none
`include "omni_wheel_kinematics_core_macros.svh"
module omni_wheel_kinematics_core
    import owk_pkg::*;
#(
    parameter int SINE_ENTRIES = SINE_ENTRIES_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // action[1:0], heading[16:2], vel_x[32:17], vel_y[48:33], rot_rate[64:49],
    // wheel_in_0[80:65], wheel_in_1[96:81], wheel_in_2[112:97], wheel_in_3[128:113]
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // wheel_out_0..3[55:0] 14 bits each, body_x[87:56], body_y[119:88], body_rot[151:120]
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata
);
    localparam int DEPTH = 6;

    logic [ANG_W-1:0]   r_mount [NUM_WHEELS];
    logic [SCALE_W-1:0] r_scale;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mount[0] <= 15'd2880;
            r_mount[1] <= 15'd8640;
            r_mount[2] <= 15'd14400;
            r_mount[3] <= 15'd20160;
            r_scale <= 24'd10294;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MOUNT_0: r_mount[0] <= i_cfg_data[ANG_W-1:0];
                CFG_MOUNT_1: r_mount[1] <= i_cfg_data[ANG_W-1:0];
                CFG_MOUNT_2: r_mount[2] <= i_cfg_data[ANG_W-1:0];
                CFG_MOUNT_3: r_mount[3] <= i_cfg_data[ANG_W-1:0];
                CFG_ODOM:    r_scale <= i_cfg_data[SCALE_W-1:0];
                default: ;
            endcase
        end
    end

    // whole pipe moves when the last stage is empty or being drained
    logic w_en;
    t_ctl r_ctl [DEPTH];
    assign w_en = !r_ctl[DEPTH-1].valid || m_axis_tready;
    assign s_axis_tready = w_en;

    t_ctl n_ctl0;
    assign n_ctl0.valid = s_axis_tvalid;
    assign n_ctl0.action = t_action'(s_axis_tdata[1:0]);
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < DEPTH; s++) r_ctl[s] <= '{valid: 1'b0, action: ACT_INVERSE};
        end else if (w_en) begin
            r_ctl[0] <= n_ctl0;
            for (int s = 1; s < DEPTH; s++) r_ctl[s] <= r_ctl[s-1];
        end
    end

    logic signed [VAL_W-1:0] w_vx, w_vy, w_rot;
    logic [ANG_W-1:0]        w_head;
    logic signed [VAL_W-1:0] w_win [NUM_WHEELS];
    assign w_head = s_axis_tdata[16:2];
    assign w_vx   = s_axis_tdata[32:17];
    assign w_vy   = s_axis_tdata[48:33];
    assign w_rot  = s_axis_tdata[64:49];
    assign w_win[0] = s_axis_tdata[80:65];
    assign w_win[1] = s_axis_tdata[96:81];
    assign w_win[2] = s_axis_tdata[112:97];
    assign w_win[3] = s_axis_tdata[128:113];

    // wheel speeds delayed to line up with the lane products
    logic signed [VAL_W-1:0] r_wd [3][NUM_WHEELS];
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_wd[0] <= w_win;
            r_wd[1] <= r_wd[0];
            r_wd[2] <= r_wd[1];
        end
    end

    logic signed [WOUT_W-1:0] w_wo [NUM_WHEELS];
    logic signed [33:0]       w_px [NUM_WHEELS];
    logic signed [33:0]       w_py [NUM_WHEELS];
    logic signed [WOUT_W-1:0] r_wo [NUM_WHEELS];
    t_action                  r_act3;

    for (genvar g = 0; g < NUM_WHEELS; g++) begin : g_lane
        owk_lane #(.SINE_ENTRIES(SINE_ENTRIES)) u_lane (
            .i_clk      (i_clk),
            .i_en       (w_en),
            .i_heading  (w_head),
            .i_mount    (r_mount[g]),
            .i_vel_x    (w_vx),
            .i_vel_y    (w_vy),
            .i_rot      (w_rot),
            .i_wheel    (w_win[g]),
            .o_wheel_out(w_wo[g]),
            .o_px       (w_px[g]),
            .o_py       (w_py[g])
        );
    end

    // lane outputs land after stage 4; hold them two more stages to meet the merge
    logic signed [WOUT_W-1:0] r_wo_d [NUM_WHEELS];
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_wo_d <= w_wo;
            r_wo <= r_wo_d;
        end
    end
    assign r_act3 = r_ctl[2].action;

    logic signed [BODY_W-1:0] w_bx, w_by, w_br;
    owk_merge u_merge (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_action(r_act3),
        .i_scale (r_scale),
        .i_px    (w_px),
        .i_py    (w_py),
        .i_wh    (r_wd[2]),
        .o_bx    (w_bx),
        .o_by    (w_by),
        .o_br    (w_br)
    );

    logic w_inv;
    assign w_inv = (r_ctl[DEPTH-1].action == ACT_INVERSE);
    assign m_axis_tvalid = r_ctl[DEPTH-1].valid;
    always_comb begin
        m_axis_tdata = '0;
        for (int g = 0; g < NUM_WHEELS; g++)
            m_axis_tdata[g*WOUT_W +: WOUT_W] = w_inv ? r_wo[g] : '0;
        m_axis_tdata[56 +: BODY_W]  = w_bx;
        m_axis_tdata[88 +: BODY_W]  = w_by;
        m_axis_tdata[120 +: BODY_W] = w_br;
    end

    `OWK_ASSERT(a_stall_holds, i_clk, i_rst_n,
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata),
        "result beat changed while stalled")
    `OWK_ASSERT(a_ready_when_drain, i_clk, i_rst_n,
        m_axis_tready |-> s_axis_tready, "input stalled while output drains")
    `OWK_ASSERT_ALWAYS(a_reset_empty, i_clk,
        !i_rst_n |=> !m_axis_tvalid, "result valid right after reset")
endmodule
`default_nettype wire
